### rtl/core/bcrp_pkg.sv
// shared constants, codes and table functions for the relative permeability core
`timescale 1ns / 1ps
package bcrp_pkg;

  localparam int unsigned FRAC_BITS_DEF       = 16;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 8;

  localparam logic [1:0] REG_RES_LIQ  = 2'd0;
  localparam logic [1:0] REG_RES_GAS  = 2'd1;
  localparam logic [1:0] REG_MIN_PERM = 2'd2;
  localparam logic [1:0] REG_LAMBDA   = 2'd3;

  localparam logic [1:0] OP_VALUE = 2'd0;
  localparam logic [1:0] OP_DERIV = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_CFG   = 2'd3;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    v = x;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry idx of the 2^(-i/2^a) table in Q.f
  function automatic logic [63:0] exp_entry(input int unsigned f, input int unsigned a,
                                            input int unsigned idx);
    logic [63:0] c [32];
    logic [63:0] v;
    for (int k = 0; k < 32; k++) c[k] = '0;
    c[1] = isqrt64(64'd1 << (2 * f - 1));
    for (int k = 2; k <= a; k++) c[k] = isqrt64(c[k-1] << f);
    v = 64'd1 << f;
    for (int k = 1; k <= a; k++) begin
      if (((idx >> (a - k)) & 1) != 0) v = (v * c[k]) >> f;
    end
    if (idx == (1 << a)) v = (64'd1 << f) >> 1;
    return v;
  endfunction

endpackage

### rtl/core/bcrp_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module bcrp_div #(
  parameter int unsigned DNW = 17,
  parameter int unsigned QB  = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [DNW-1:0] rem_i,
  input  logic [QB-1:0]  bits_i,
  input  logic [DNW-1:0] den_i,
  output logic [QB-1:0]  quot_o
);

  logic [DNW-1:0] r_q [QB];
  logic [QB-1:0]  b_q [QB];
  logic [QB-1:0]  q_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [DNW-1:0] r_in;
    logic [QB-1:0]  b_in;
    logic [QB-1:0]  q_in;
    logic [DNW:0]   trial;
    logic           ge;
    if (j == 0) begin : g_first
      assign r_in = rem_i;
      assign b_in = bits_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign b_in = b_q[j-1];
      assign q_in = q_q[j-1];
    end
    assign trial = {r_in, b_in[QB-1]};
    assign ge    = trial >= {1'b0, den_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j] <= ge ? DNW'(trial - {1'b0, den_i}) : trial[DNW-1:0];
        b_q[j] <= b_in << 1;
        q_q[j] <= {q_in[QB-2:0], ge};
      end
    end
  end

  assign quot_o = q_q[QB-1];

endmodule

### rtl/core/bcrp_log.sv
// normalisation and log2 of the effective saturation, one squaring per stage
`timescale 1ns / 1ps
module bcrp_log #(
  parameter int unsigned FRAC_BITS = bcrp_pkg::FRAC_BITS_DEF,
  parameter int unsigned LGW       = $clog2(FRAC_BITS + 1) + FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] se_i,
  output logic [LGW-1:0]       lg_o,
  output logic                 zero_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned K  = $clog2(F);
  localparam int unsigned NW = $clog2(F + 1);

  logic [F-1:0]  w_q  [K];
  logic [NW-1:0] c_q  [K];
  logic          zc_q [K];

  for (genvar k = 0; k < K; k++) begin : g_clz
    localparam int unsigned S = 1 << (K - 1 - k);
    logic [F-1:0]  w_in;
    logic [NW-1:0] c_in;
    logic          z_in;
    if (k == 0) begin : g_first
      assign w_in = se_i;
      assign c_in = '0;
      assign z_in = (se_i == '0);
    end else begin : g_next
      assign w_in = w_q[k-1];
      assign c_in = c_q[k-1];
      assign z_in = zc_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zc_q[k] <= z_in;
        if (w_in[F-1 -: S] == '0) begin
          w_q[k] <= w_in << S;
          c_q[k] <= c_in + NW'(S);
        end else begin
          w_q[k] <= w_in;
          c_q[k] <= c_in;
        end
      end
    end
  end

  logic [F:0]    y_q  [F];
  logic [F-1:0]  r_q  [F];
  logic [NW-1:0] n_q  [F];
  logic          zs_q [F];

  for (genvar j = 0; j < F; j++) begin : g_sq
    logic [F:0]     y_in;
    logic [F-1:0]   r_in;
    logic [NW-1:0]  n_in;
    logic           z_in;
    logic [2*F+1:0] prod;
    logic [F+1:0]   sq;
    if (j == 0) begin : g_first
      assign y_in = {w_q[K-1], 1'b0};
      assign r_in = '0;
      assign n_in = c_q[K-1] + NW'(1);
      assign z_in = zc_q[K-1];
    end else begin : g_next
      assign y_in = y_q[j-1];
      assign r_in = r_q[j-1];
      assign n_in = n_q[j-1];
      assign z_in = zs_q[j-1];
    end
    assign prod = y_in * y_in;
    assign sq   = prod[2*F+1:F];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[j]  <= sq[F+1] ? sq[F+1:1] : sq[F:0];
        r_q[j]  <= {r_in[F-2:0], sq[F+1]};
        n_q[j]  <= n_in;
        zs_q[j] <= z_in;
      end
    end
  end

  logic [LGW-1:0] lg_q;
  logic           z_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_q <= LGW'({n_q[F-1], {F{1'b0}}}) - LGW'(r_q[F-1]);
      z_q  <= zs_q[F-1];
    end
  end

  assign lg_o   = lg_q;
  assign zero_o = z_q;

endmodule

### rtl/core/bcrp_exp2.sv
// exponent product and table based 2^-t with linear interpolation
`timescale 1ns / 1ps
module bcrp_exp2 #(
  parameter int unsigned FRAC_BITS       = bcrp_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = bcrp_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned XW              = 18 + FRAC_BITS,
  parameter int unsigned LGW             = $clog2(FRAC_BITS + 1) + FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [XW-1:0]      x_i,
  input  logic [LGW-1:0]     lg_i,
  input  logic               zero_i,
  output logic [FRAC_BITS:0] pow_o
);

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned ADDR = (TABLE_ADDR_BITS < F) ? TABLE_ADDR_BITS : F;
  localparam int unsigned LB   = F - ADDR;
  localparam int unsigned LOWW = (LB > 0) ? LB : 1;
  localparam int unsigned ENT  = (1 << ADDR) + 1;
  localparam int unsigned XL   = XW / 2;
  localparam int unsigned XH   = XW - XL;
  localparam int unsigned PW   = XW + LGW;
  localparam int unsigned HW   = PW - 2 * F;
  localparam int unsigned NW   = $clog2(F + 1);

  logic [F:0] tbl [ENT];

  for (genvar g = 0; g < ENT; g++) begin : g_tbl
    localparam logic [63:0] EV = bcrp_pkg::exp_entry(F, ADDR, g);
    assign tbl[g] = EV[F:0];
  end

  // partial products of x and the log
  logic [XL+LGW-1:0] pl_q;
  logic [XH+LGW-1:0] ph_q;
  logic              z1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= x_i[XL-1:0] * lg_i;
      ph_q <= x_i[XW-1:XL] * lg_i;
      z1_q <= zero_i;
    end
  end

  logic [PW-1:0] prod;
  logic [F-1:0]  tf2_q;
  logic [NW-1:0] n2_q;
  logic          k2_q;

  assign prod = {ph_q, {XL{1'b0}}} + PW'(pl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tf2_q <= prod[2*F-1:F];
      n2_q  <= prod[2*F+NW-1:2*F];
      k2_q  <= z1_q | (prod[PW-1:2*F] > HW'(F));
    end
  end

  logic [ADDR-1:0] idx;
  logic [ADDR:0]   idx1;
  logic [LOWW-1:0] low;
  logic [F:0]      hiv;
  logic [F:0]      lov;

  assign idx  = tf2_q[F-1 -: ADDR];
  assign idx1 = {1'b0, idx} + (ADDR + 1)'(1);
  assign hiv  = tbl[{1'b0, idx}];
  assign lov  = tbl[idx1];

  if (LB > 0) begin : g_low
    assign low = tf2_q[LOWW-1:0];
  end else begin : g_nolow
    assign low = '0;
  end

  logic [F:0]      hiv3_q;
  logic [F:0]      diff3_q;
  logic [LOWW-1:0] low3_q;
  logic [NW-1:0]   n3_q;
  logic            k3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hiv3_q  <= hiv;
      diff3_q <= (hiv > lov) ? hiv - lov : '0;
      low3_q  <= low;
      n3_q    <= n2_q;
      k3_q    <= k2_q;
    end
  end

  logic [F+LOWW:0] pd4_q;
  logic [F:0]      hiv4_q;
  logic [NW-1:0]   n4_q;
  logic            k4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd4_q  <= diff3_q * low3_q;
      hiv4_q <= hiv3_q;
      n4_q   <= n3_q;
      k4_q   <= k3_q;
    end
  end

  logic [F:0] v;
  logic [F:0] pow_q;

  assign v = hiv4_q - (F + 1)'(pd4_q >> LB);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pow_q <= k4_q ? '0 : (v >> n4_q);
    end
  end

  assign pow_o = pow_q;

endmodule

### rtl/core/brooks_corey_rel_perm_core.sv
// top level of the brooks-corey relative permeability pipeline
//
// input beats carry the liquid saturation in s_tdata and the operation in s_tuser;
// each beat gives exactly one output beat with the result in m_tdata and the
// status in m_tuser, in input order.
// registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i, only while
// idle: the user must keep to this, as the block itself does not enforce it.
// the exponents e and e-1 come from a shared serial divider that runs after reset
// and after every register write, with s_tready low meanwhile.
// the saturation divider (FRAC_BITS stages), the log2 squaring chain (FRAC_BITS
// stages) and the 32 stage final divider lie between accepted beat and m_tvalid.
// throughput: one beat per cycle while s_tready is high; it drops while the
// exponents recompute and while the output stalls.
// when m_tready is low with a result waiting, the pipeline holds every stage
// (bubbles at its tail are still filled) and s_tready drops; nothing is lost.
// reset empties the pipeline and restores the register defaults.
`timescale 1ns / 1ps
module brooks_corey_rel_perm_core #(
  parameter int unsigned FRAC_BITS       = bcrp_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = bcrp_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // liquid_sat [16:0], zero fill
  input  logic [1:0]  s_tuser,  // operation [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // result_value [31:0]
  output logic [1:0]  m_tuser   // status [1:0]
);

  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned NW      = $clog2(F + 1);
  localparam int unsigned LGW     = NW + F;
  localparam int unsigned QW      = 18 + F;
  localparam int unsigned CDW     = 26 + F;
  localparam int unsigned CCW     = $clog2(CDW + 1);
  localparam int unsigned K       = $clog2(F);
  localparam int unsigned LAT_LOG = K + F + 1;
  localparam int unsigned A1      = F + LAT_LOG + 5;
  localparam int unsigned KL      = 35;
  localparam int unsigned OL      = 32;
  localparam int unsigned TOT     = A1 + KL;
  localparam int unsigned DL      = QW / 2;
  localparam int unsigned DH      = QW - DL;
  localparam int unsigned SH_DN   = (F > 16) ? F - 16 : 0;
  localparam int unsigned SH_UP   = (F < 16) ? 16 - F : 0;

  typedef struct packed {
    logic        vld;
    logic        fixed;
    logic        deriv;
    logic [1:0]  st;
    logic [16:0] fres;
  } meta_t;

  // configuration registers
  logic [15:0] rl_q, rg_q;
  logic [16:0] min_q;
  logic [23:0] lam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_q  <= '0;
      rg_q  <= '0;
      min_q <= '0;
      lam_q <= 24'd131072;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcrp_pkg::REG_RES_LIQ:  rl_q  <= cfg_wdata_i[15:0];
        bcrp_pkg::REG_RES_GAS:  rg_q  <= cfg_wdata_i[15:0];
        bcrp_pkg::REG_MIN_PERM: min_q <= cfg_wdata_i[16:0];
        bcrp_pkg::REG_LAMBDA:   lam_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // serial divider for e = (3l+2)/l and e-1 = (2l+2)/l
  logic           cstart_q;
  logic [CCW-1:0] ccnt_q;
  logic [23:0]    crem_e_q, crem_m_q;
  logic [CDW-1:0] csh_e_q, csh_m_q;
  logic [QW-1:0]  ef_q, em_q;
  logic [25:0]    ne, nm;
  logic [24:0]    trial_e, trial_m;
  logic           ge_e, ge_m;
  logic           calc_busy;

  assign ne        = {2'b0, lam_q} + {1'b0, lam_q, 1'b0} + 26'd131072;
  assign nm        = {1'b0, lam_q, 1'b0} + 26'd131072;
  assign trial_e   = {crem_e_q, csh_e_q[CDW-1]};
  assign trial_m   = {crem_m_q, csh_m_q[CDW-1]};
  assign ge_e      = trial_e >= {1'b0, lam_q};
  assign ge_m      = trial_m >= {1'b0, lam_q};
  assign calc_busy = cstart_q | (ccnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cstart_q <= 1'b1;
      ccnt_q   <= '0;
    end else begin
      cstart_q <= cfg_we_i;
      if (cstart_q) begin
        ccnt_q   <= CCW'(CDW);
        csh_e_q  <= {ne, {F{1'b0}}};
        csh_m_q  <= {nm, {F{1'b0}}};
        crem_e_q <= '0;
        crem_m_q <= '0;
      end else if (ccnt_q != '0) begin
        ccnt_q   <= ccnt_q - CCW'(1);
        csh_e_q  <= csh_e_q << 1;
        csh_m_q  <= csh_m_q << 1;
        crem_e_q <= ge_e ? 24'(trial_e - {1'b0, lam_q}) : trial_e[23:0];
        crem_m_q <= ge_m ? 24'(trial_m - {1'b0, lam_q}) : trial_m[23:0];
        ef_q     <= {ef_q[QW-2:0], ge_e};
        em_q     <= {em_q[QW-2:0], ge_m};
      end
    end
  end

  // entry decode
  logic [17:0]        rsum;
  logic [16:0]        den;
  logic               cfg_bad;
  logic signed [17:0] num;
  logic               num_ge;
  meta_t              meta_in;
  logic               en, out_load, s_fire;
  meta_t              meta_q [TOT];

  assign rsum    = {2'b0, rl_q} + {2'b0, rg_q};
  assign den     = 17'(18'd65536 - rsum);
  assign cfg_bad = (lam_q == '0) | (rsum >= 18'd65536) | (min_q > 17'd65536);
  assign num     = $signed({1'b0, s_tdata[16:0]}) - $signed({2'b0, rl_q});
  assign num_ge  = !num[17] && (num[16:0] >= den);

  assign out_load = !m_tvalid | m_tready;
  assign en       = out_load | !meta_q[TOT-1].vld;
  assign s_tready = en & !calc_busy;
  assign s_fire   = s_tvalid & s_tready;

  always_comb begin
    meta_in       = '0;
    meta_in.vld   = s_fire;
    meta_in.fixed = 1'b1;
    meta_in.st    = bcrp_pkg::ST_OK;
    if (cfg_bad) begin
      meta_in.st = bcrp_pkg::ST_CFG;
    end else if (s_tuser != bcrp_pkg::OP_VALUE && s_tuser != bcrp_pkg::OP_DERIV) begin
      meta_in.st = bcrp_pkg::ST_UNSUP;
    end else if (s_tuser == bcrp_pkg::OP_VALUE) begin
      if (num_ge) begin
        meta_in.fres = 17'd65536;
      end else if (num[17] || num == '0) begin
        meta_in.fres = min_q;
      end else begin
        meta_in.fixed = 1'b0;
      end
    end else begin
      meta_in.deriv = 1'b1;
      if (!(num[17] || num == '0 || num_ge)) meta_in.fixed = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOT; i++) meta_q[i] <= '0;
    end else if (en) begin
      meta_q[0] <= meta_in;
      for (int i = 1; i < TOT; i++) meta_q[i] <= meta_q[i-1];
    end
  end

  // effective saturation, log and the two power lanes
  logic [F-1:0]   se;
  logic [LGW-1:0] lg;
  logic           lg_zero;
  logic [F:0]     pow_e, pow_m;

  bcrp_div #(
    .DNW (17),
    .QB  (F)
  ) u_div_se (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (meta_in.fixed ? 17'd0 : num[16:0]),
    .bits_i ('0),
    .den_i  (den),
    .quot_o (se)
  );

  bcrp_log #(
    .FRAC_BITS (F),
    .LGW       (LGW)
  ) u_log (
    .clk_i  (clk_i),
    .en_i   (en),
    .se_i   (se),
    .lg_o   (lg),
    .zero_o (lg_zero)
  );

  bcrp_exp2 #(
    .FRAC_BITS       (F),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .XW              (QW),
    .LGW             (LGW)
  ) u_exp_e (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (ef_q),
    .lg_i   (lg),
    .zero_i (lg_zero),
    .pow_o  (pow_e)
  );

  bcrp_exp2 #(
    .FRAC_BITS       (F),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .XW              (QW),
    .LGW             (LGW)
  ) u_exp_m (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (em_q),
    .lg_i   (lg),
    .zero_i (lg_zero),
    .pow_o  (pow_m)
  );

  // value in q1.16 travels beside the derivative path
  logic [F+16:0] k16w;
  logic [16:0]   k16_q [KL];

  assign k16w = ({16'b0, pow_e} >> SH_DN) << SH_UP;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k16_q[0] <= k16w[16:0];
      for (int i = 1; i < KL; i++) k16_q[i] <= k16_q[i-1];
    end
  end

  // e * se^(e-1), then overflow check ahead of the final divider
  logic [DL+F:0]   dpl_q;
  logic [DH+F:0]   dph_q;
  logic [QW+F:0]   dsum;
  logic [QW:0]     d_q;
  logic [QW-F:0]   dh;
  logic [16:0]     rem2_q;
  logic [31:0]     bits2_q;
  logic            ov2_q;
  logic            ov_q [OL];
  logic [31:0]     q2;

  assign dsum = {dph_q, {DL{1'b0}}} + (QW + F + 1)'(dpl_q);
  assign dh   = d_q[QW:F];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dpl_q   <= ef_q[DL-1:0] * pow_m;
      dph_q   <= ef_q[QW-1:DL] * pow_m;
      d_q     <= dsum[QW+F:F];
      ov2_q   <= dh >= (QW - F + 1)'(den);
      rem2_q  <= (dh >= (QW - F + 1)'(den)) ? 17'd0 : dh[16:0];
      bits2_q <= {d_q[F-1:0], {(32 - F){1'b0}}};
      ov_q[0] <= ov2_q;
      for (int i = 1; i < OL; i++) ov_q[i] <= ov_q[i-1];
    end
  end

  bcrp_div #(
    .DNW (17),
    .QB  (32)
  ) u_div_out (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (rem2_q),
    .bits_i (bits2_q),
    .den_i  (den),
    .quot_o (q2)
  );

  // result select and output register
  meta_t       last;
  logic [16:0] kk;
  logic [31:0] res_d;
  logic [1:0]  st_d;
  logic        m_tvalid_q;
  logic [31:0] m_tdata_q;
  logic [1:0]  m_tuser_q;

  assign last = meta_q[TOT-1];
  assign kk   = k16_q[KL-1];

  always_comb begin
    res_d = '0;
    st_d  = last.st;
    if (last.fixed) begin
      res_d = {15'b0, last.fres};
    end else if (!last.deriv) begin
      res_d = {15'b0, (kk > min_q) ? kk : min_q};
    end else if (kk > min_q) begin
      if (ov_q[OL-1]) begin
        res_d = '1;
        st_d  = bcrp_pkg::ST_SAT;
      end else begin
        res_d = q2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= res_d;
      m_tuser_q <= st_d;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;
  assign m_tuser  = m_tuser_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready |-> !calc_busy)
    else $error("input accepted while exponents recompute");

  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tuser == bcrp_pkg::ST_SAT) |-> (m_tdata == 32'hFFFF_FFFF))
    else $error("saturated status without full scale result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && (m_tuser == bcrp_pkg::ST_CFG || m_tuser == bcrp_pkg::ST_UNSUP))
      |-> (m_tdata == '0))
    else $error("error status with nonzero result");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cstart_q |=> (ccnt_q == CCW'(CDW)))
    else $error("exponent divider did not start");

endmodule
